// File: rtl/psc_pkg.sv
// Shared types and constants for the PID speed controller.
// Used by the channel interfaces, the register block and the top level.
`timescale 1ns / 1ps

package psc_pkg;

  localparam int DataW  = 16;
  localparam int GainW  = 16;
  localparam int LimW   = 15;
  localparam int IdxW   = 3;
  localparam int ProdW  = 32;
  localparam int DiffW  = 17;
  localparam int DprodW = 33;
  localparam int AccW   = 33;
  localparam int IntegW = 24;
  localparam int SumW   = 35;
  localparam int FracW  = 8;
  localparam int QuotW  = SumW - FracW;

  typedef logic [IdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_KP_GAIN        = 3'd0;
  localparam cfg_idx_t REG_KI_GAIN        = 3'd1;
  localparam cfg_idx_t REG_KD_GAIN        = 3'd2;
  localparam cfg_idx_t REG_INTEGRAL_LIMIT = 3'd3;
  localparam cfg_idx_t REG_OUTPUT_LIMIT   = 3'd4;

  localparam logic [GainW-1:0] KP_GAIN_RESET        = 16'hE700;
  localparam logic [GainW-1:0] KI_GAIN_RESET        = 16'hFF4D;
  localparam logic [GainW-1:0] KD_GAIN_RESET        = 16'h0000;
  localparam logic [LimW-1:0]  INTEGRAL_LIMIT_RESET = 15'd1400;
  localparam logic [LimW-1:0]  OUTPUT_LIMIT_RESET   = 15'd1400;

  typedef struct packed {
    logic [GainW-1:0] kp_gain;
    logic [GainW-1:0] ki_gain;
    logic [GainW-1:0] kd_gain;
    logic [LimW-1:0]  integral_limit;
    logic [LimW-1:0]  output_limit;
  } psc_cfg_t;

endpackage

// File: rtl/psc_in_if.sv
// Input channel: one word carries a measured and a target speed.
// Depends on psc_pkg for field widths.
`timescale 1ns / 1ps

interface psc_in_if;
  logic                        valid;
  logic                        ready;
  logic [psc_pkg::DataW-1:0]   measured_speed;
  logic [psc_pkg::DataW-1:0]   target_speed;

  modport source (output valid, output measured_speed, output target_speed, input ready);
  modport sink   (input valid, input measured_speed, input target_speed, output ready);
endinterface

// File: rtl/psc_out_if.sv
// Output channel: one word carries a drive value.
// Depends on psc_pkg for field widths.
`timescale 1ns / 1ps

interface psc_out_if;
  logic                        valid;
  logic                        ready;
  logic [psc_pkg::DataW-1:0]   drive_value;

  modport source (output valid, output drive_value, input ready);
  modport sink   (input valid, input drive_value, output ready);
endinterface

// File: rtl/psc_cfg_regs.sv
// Configuration registers of the PID speed controller: gains and limits.
// Depends on psc_pkg for the register codes, reset values and config struct.
`timescale 1ns / 1ps

module psc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  psc_pkg::cfg_idx_t           cfg_index,
  input  logic [psc_pkg::GainW-1:0]   cfg_data,
  output psc_pkg::psc_cfg_t           cfg
);
  import psc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_gain        <= KP_GAIN_RESET;
      cfg.ki_gain        <= KI_GAIN_RESET;
      cfg.kd_gain        <= KD_GAIN_RESET;
      cfg.integral_limit <= INTEGRAL_LIMIT_RESET;
      cfg.output_limit   <= OUTPUT_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KP_GAIN:        cfg.kp_gain        <= cfg_data;
        REG_KI_GAIN:        cfg.ki_gain        <= cfg_data;
        REG_KD_GAIN:        cfg.kd_gain        <= cfg_data;
        REG_INTEGRAL_LIMIT: cfg.integral_limit <= cfg_data[LimW-1:0];
        REG_OUTPUT_LIMIT:   cfg.output_limit   <= cfg_data[LimW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/pid_speed_controller.sv
// PID speed controller: saturated error, P, clamped I and D terms, clamped sum.
// An accepted word passes the stage 1, 2 and 3 registers into the stage 4 drive register.
// Throughput: one word per cycle unless stalled; the integral updates once per word in stage 3.
// Each stage holds its word only while the next stage is full and stalled.
// Reset (synchronous, active high) clears the pipeline, the integral and the
// previous error, and returns gains and limits to their default values.
`timescale 1ns / 1ps

module pid_speed_controller (
  input  logic                        clk,
  input  logic                        rst,
  psc_in_if.sink                      in_ch,
  psc_out_if.source                   out_ch,
  input  logic                        cfg_write,
  input  psc_pkg::cfg_idx_t           cfg_index,
  input  logic [psc_pkg::GainW-1:0]   cfg_data
);
  import psc_pkg::*;

  psc_cfg_t cfg;

  psc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic v1, v2, v3, out_valid;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [DataW-1:0]  meas1, targ1;
  logic signed [DataW-1:0]  previous_error;
  logic signed [ProdW-1:0]  p2, kie2;
  logic signed [DprodW-1:0] d2;
  logic signed [IntegW-1:0] integral_sum;
  logic signed [ProdW-1:0]  p3;
  logic signed [DprodW-1:0] d3;
  logic signed [IntegW-1:0] integ3;
  logic [DataW-1:0]         drive;

  logic signed [DiffW-1:0]  raw_err;
  logic signed [DataW-1:0]  err;
  logic signed [DiffW-1:0]  err_delta;
  logic signed [ProdW-1:0]  p_next, kie_next;
  logic signed [DprodW-1:0] d_next;

  logic signed [AccW-1:0]   integ_acc, integ_lim;
  logic signed [IntegW-1:0] integral_sum_next;

  logic signed [SumW-1:0]   total;
  logic signed [QuotW-1:0]  quot, out_lim, quot_clamped;

  assign rdy4 = !out_valid || out_ch.ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign in_ch.ready       = rdy1;
  assign out_ch.valid      = out_valid;
  assign out_ch.drive_value = drive;

  // stage 2: saturated error and the three products
  always_comb begin
    raw_err = {meas1[DataW-1], meas1} - {targ1[DataW-1], targ1};
    if (raw_err[DiffW-1] != raw_err[DiffW-2]) begin
      err = raw_err[DiffW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      err = raw_err[DataW-1:0];
    end
    err_delta = {err[DataW-1], err} - {previous_error[DataW-1], previous_error};
    p_next    = ProdW'($signed(cfg.kp_gain)) * ProdW'(err);
    kie_next  = ProdW'($signed(cfg.ki_gain)) * ProdW'(err);
    d_next    = DprodW'($signed(cfg.kd_gain)) * DprodW'(err_delta);
  end

  // stage 3: integral update with symmetric clamp
  always_comb begin
    integ_acc = {{(AccW-IntegW){integral_sum[IntegW-1]}}, integral_sum}
              + {{(AccW-ProdW){kie2[ProdW-1]}}, kie2};
    integ_lim = {{(AccW-LimW-FracW){1'b0}}, cfg.integral_limit, {FracW{1'b0}}};
    if (integ_acc > integ_lim) begin
      integral_sum_next = integ_lim[IntegW-1:0];
    end else if (integ_acc < -integ_lim) begin
      integral_sum_next = IntegW'(-integ_lim);
    end else begin
      integral_sum_next = integ_acc[IntegW-1:0];
    end
  end

  // stage 4: sum, truncate toward zero, output clamp
  always_comb begin
    total = {{(SumW-ProdW){p3[ProdW-1]}}, p3}
          + {{(SumW-IntegW){integ3[IntegW-1]}}, integ3}
          + {{(SumW-DprodW){d3[DprodW-1]}}, d3};
    quot  = total[SumW-1:FracW]
          + {{(QuotW-1){1'b0}}, total[SumW-1] && (|total[FracW-1:0])};
    out_lim = {{(QuotW-LimW){1'b0}}, cfg.output_limit};
    if (quot > out_lim) begin
      quot_clamped = out_lim;
    end else if (quot < -out_lim) begin
      quot_clamped = -out_lim;
    end else begin
      quot_clamped = quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1             <= 1'b0;
      v2             <= 1'b0;
      v3             <= 1'b0;
      out_valid      <= 1'b0;
      previous_error <= '0;
      integral_sum   <= '0;
    end else begin
      if (rdy1) begin
        v1 <= in_ch.valid;
      end
      if (rdy2) begin
        v2 <= v1;
        if (v1) begin
          previous_error <= err;
        end
      end
      if (rdy3) begin
        v3 <= v2;
        if (v2) begin
          integral_sum <= integral_sum_next;
        end
      end
      if (rdy4) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      meas1 <= in_ch.measured_speed;
      targ1 <= in_ch.target_speed;
    end
    if (rdy2 && v1) begin
      p2   <= p_next;
      kie2 <= kie_next;
      d2   <= d_next;
    end
    if (rdy3 && v2) begin
      p3     <= p2;
      d3     <= d2;
      integ3 <= integral_sum_next;
    end
    if (rdy4 && v3) begin
      drive <= quot_clamped[DataW-1:0];
    end
  end

endmodule

// File: verif/pid_speed_controller_tb.sv
// Self-checking testbench for pid_speed_controller: directed corner words, then
// randomized gain/limit settings, first with random stalls on both channels, then without.
// Depends on psc_pkg and the psc_in_if / psc_out_if channel interfaces.
`timescale 1ns / 1ps

module pid_speed_controller_tb;
  import psc_pkg::*;

  localparam cfg_idx_t REG_SPARE_LO = REG_OUTPUT_LIMIT + 3'd1;
  localparam cfg_idx_t REG_SPARE_HI = '1;
  localparam int TailCycles = 12;

  logic clk;
  logic rst;
  logic cfg_write;
  cfg_idx_t cfg_index;
  logic [GainW-1:0] cfg_data;

  psc_in_if  in_ch ();
  psc_out_if out_ch ();

  pid_speed_controller u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // controller copy: registers and loop state
  logic signed [GainW-1:0]  kp_q;
  logic signed [GainW-1:0]  ki_q;
  logic signed [GainW-1:0]  kd_q;
  logic        [LimW-1:0]   integ_limit_q;
  logic        [LimW-1:0]   out_limit_q;
  logic signed [IntegW-1:0] integ_q;
  logic signed [DataW-1:0]  prev_err_q;

  logic [DataW-1:0] drive_expected[$];
  bit idle_on;
  int errors;
  int words_sent;
  int words_checked;
  int settings_used;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [DataW-1:0] pid_next_drive(logic [DataW-1:0] meas,
                                                      logic [DataW-1:0] targ);
    longint err, p, acc, lim, d, sum, quo, olim;
    err = longint'($signed(meas)) - longint'($signed(targ));
    if (err > 32767) err = 32767;
    else if (err < -32768) err = -32768;
    p = longint'(kp_q) * err;
    acc = longint'(integ_q) + longint'(ki_q) * err;
    lim = longint'(integ_limit_q) * 256;
    if (acc > lim) acc = lim;
    else if (acc < -lim) acc = -lim;
    integ_q = acc[IntegW-1:0];
    d = longint'(kd_q) * (err - longint'(prev_err_q));
    prev_err_q = err[DataW-1:0];
    sum = p + acc + d;
    quo = sum / 256;
    olim = longint'(out_limit_q);
    if (quo > olim) quo = olim;
    else if (quo < -olim) quo = -olim;
    return quo[DataW-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [DataW-1:0] got, logic [DataW-1:0] want);
    errors++;
    $display("tb: mismatch at %0t: %s got %0d expected %0d", $realtime, what,
             $signed(got), $signed(want));
  endtask

  // drive word checker
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (drive_expected.size() == 0) begin
        report_mismatch("unexpected drive word", out_ch.drive_value, '0);
      end else begin
        if (out_ch.drive_value !== drive_expected[0])
          report_mismatch("drive_value", out_ch.drive_value, drive_expected[0]);
        void'(drive_expected.pop_front());
        words_checked++;
      end
    end
  end

  // output back-pressure in random bursts
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_speeds(logic [DataW-1:0] meas, logic [DataW-1:0] targ);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.measured_speed <= meas;
    in_ch.target_speed <= targ;
    do @(posedge clk); while (!in_ch.ready);
    drive_expected.push_back(pid_next_drive(meas, targ));
    words_sent++;
    @(negedge clk);
  endtask

  // hold off until every drive word is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (drive_expected.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [GainW-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_KP_GAIN:        kp_q = val;
      REG_KI_GAIN:        ki_q = val;
      REG_KD_GAIN:        kd_q = val;
      REG_INTEGRAL_LIMIT: integ_limit_q = val[LimW-1:0];
      REG_OUTPUT_LIMIT:   out_limit_q = val[LimW-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_gains(logic [GainW-1:0] kp, logic [GainW-1:0] ki, logic [GainW-1:0] kd,
                           logic [GainW-1:0] ilim, logic [GainW-1:0] olim);
    write_reg(REG_KP_GAIN, kp);
    write_reg(REG_KI_GAIN, ki);
    write_reg(REG_KD_GAIN, kd);
    write_reg(REG_INTEGRAL_LIMIT, ilim);
    write_reg(REG_OUTPUT_LIMIT, olim);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [DataW-1:0] corner_speed(int pick);
    case (pick)
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [GainW-1:0] rand_gain();
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 2047)) - 1024);
    endcase
  endfunction

  function automatic logic [GainW-1:0] rand_limit();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(0, 3000));
    endcase
  endfunction

  task automatic send_random_word();
    logic [DataW-1:0] meas, targ;
    case ($urandom_range(0, 9))
      0: begin
        meas = 16'($urandom);
        targ = 16'($urandom);
      end
      1: begin
        meas = corner_speed($urandom_range(0, 3));
        targ = corner_speed($urandom_range(0, 3));
      end
      default: begin
        targ = 16'(int'($urandom_range(0, 4000)) - 2000);
        meas = targ + 16'(int'($urandom_range(0, 200)) - 100);
      end
    endcase
    send_speeds(meas, targ);
  endtask

  task automatic test_default_gains();
    send_speeds(16'd0, 16'd0);
    send_speeds(16'd100, 16'd50);
    send_speeds(16'hFF9C, 16'd0);
    send_speeds(16'd1500, 16'd1000);
    send_speeds(16'd3000, 16'd0);
    send_speeds(16'd3000, 16'd0);
    drain();
  endtask

  task automatic test_error_saturation();
    set_gains(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_speeds(16'h7FFF, 16'h8000);
    send_speeds(16'h8000, 16'h7FFF);
    send_speeds(16'h7FFF, 16'h8000);
    drain();
    set_gains(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
    send_speeds(16'h8000, 16'h7FFF);
    send_speeds(16'h7FFF, 16'h8000);
    send_speeds(16'h0000, 16'h0001);
    drain();
  endtask

  task automatic test_zero_limits();
    set_gains(16'h0100, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
    send_speeds(16'd500, 16'd0);
    send_speeds(16'h7FFF, 16'h8000);
    drain();
    set_gains(16'h0100, 16'h0100, 16'h0100, 16'h0000, 16'h7FFF);
    send_speeds(16'd500, 16'd0);
    send_speeds(16'h8000, 16'd100);
    drain();
  endtask

  task automatic test_register_decode();
    write_reg(REG_KP_GAIN, 16'h0200);
    write_reg(REG_SPARE_LO, 16'($urandom));
    write_reg(REG_SPARE_HI, 16'($urandom));
    write_reg(REG_INTEGRAL_LIMIT, 16'h8005);
    write_reg(REG_OUTPUT_LIMIT, 16'hFFFF);
    cfg_write <= 1'b0;
    settings_used++;
    send_speeds(16'd1000, 16'd10);
    send_speeds(16'd20, 16'd900);
    send_speeds(16'd0, 16'd0);
    drain();
  endtask

  task automatic test_random_phases();
    repeat (10) begin
      set_gains(rand_gain(), rand_gain(), rand_gain(), rand_limit(), rand_limit());
      repeat (180) send_random_word();
      drain();
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    set_gains(rand_gain(), rand_gain(), rand_gain(), rand_limit(), rand_limit());
    repeat (200) send_random_word();
    drain();
  endtask

  initial begin
    rst = 1'b1;
    idle_on = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_KP_GAIN;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.measured_speed = '0;
    in_ch.target_speed = '0;
    kp_q = KP_GAIN_RESET;
    ki_q = KI_GAIN_RESET;
    kd_q = KD_GAIN_RESET;
    integ_limit_q = INTEGRAL_LIMIT_RESET;
    out_limit_q = OUTPUT_LIMIT_RESET;
    integ_q = '0;
    prev_err_q = '0;
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    settings_used = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_default_gains();
    test_error_saturation();
    test_zero_limits();
    test_register_decode();
    test_random_phases();
    test_back_to_back();

    repeat (TailCycles) @(negedge clk);
    $display("tb: %0d speed words sent, %0d drive words checked", words_sent, words_checked);
    $display("tb: %0d gain/limit settings, %0d mismatches", settings_used, errors);
    if (errors == 0 && drive_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
